/* hw/rtl/hsv_pkg.sv */
`timescale 1ns / 1ps

package hsv_pkg;

   // field widths
   localparam int HUE_W   = 9;
   localparam int PCT_W   = 7;
   localparam int LEVEL_W = 8;

   // range limits
   localparam int unsigned HUE_MAX = 360;
   localparam int unsigned PCT_MAX = 100;

   // internal widths
   localparam int SV_W   = 2 * PCT_W;   // saturation times brightness
   localparam int K_W    = 6;           // secondary weight, 0..60
   localparam int NUM_W  = 20;          // scaled component, up to 600000
   localparam int Y_W    = 18;          // num * 17 / 64, up to 159375
   localparam int PROD_W = 36;          // y times reciprocal

   // pipeline depth, the last stage is the output register
   localparam int STAGES = 5;

   // floor(y / 625) = (y * RECIP) >> QUOT_SHIFT, exact for y below 2^18
   localparam logic [Y_W-1:0] RECIP      = 18'd214749;
   localparam int             QUOT_SHIFT = 27;

   // 60-degree sectors of the color wheel
   typedef enum logic [2:0] {
      SECTOR_RED_YELLOW    = 3'd0,
      SECTOR_YELLOW_GREEN  = 3'd1,
      SECTOR_GREEN_CYAN    = 3'd2,
      SECTOR_CYAN_BLUE     = 3'd3,
      SECTOR_BLUE_MAGENTA  = 3'd4,
      SECTOR_MAGENTA_RED   = 3'd5
   } sector_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue_degrees;
      logic [PCT_W-1:0] saturation_pct;
      logic [PCT_W-1:0] brightness_pct;
   } req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] red_level;
      logic [LEVEL_W-1:0] green_level;
      logic [LEVEL_W-1:0] blue_level;
      logic               in_range;
   } rsp_type;

   // stage 1 result
   typedef struct packed {
      logic             in_range;
      logic [SV_W-1:0]  sv;
      logic [K_W-1:0]   k;
      sector_type       sector;
      logic [PCT_W-1:0] v;
   } front_type;

   // stage 3 result, channels ordered red, green, blue
   typedef struct packed {
      logic                   in_range;
      logic [2:0][Y_W-1:0]    y;
   } mix_type;

   typedef struct packed {
      logic s2;
      logic s3;
   } mix_en_type;

   typedef struct packed {
      logic s4;
      logic s5;
   } level_en_type;

endpackage

/* hw/rtl/hsv_front.sv */
`timescale 1ns / 1ps

module hsv_front (
   input  logic               clock,
   input  logic               en,
   input  hsv_pkg::req_type   req_data,
   output hsv_pkg::front_type front
);

   hsv_pkg::front_type      front_ff, front_in;
   logic [hsv_pkg::HUE_W-1:0] base;
   logic [hsv_pkg::HUE_W-1:0] offs;

   // sector lookup, range check, chroma product
   always_comb begin
      front_in.in_range = (32'(req_data.hue_degrees) <= hsv_pkg::HUE_MAX) &&
                          (32'(req_data.saturation_pct) <= hsv_pkg::PCT_MAX) &&
                          (32'(req_data.brightness_pct) <= hsv_pkg::PCT_MAX);
      front_in.sv = hsv_pkg::SV_W'(req_data.saturation_pct) *
                    hsv_pkg::SV_W'(req_data.brightness_pct);
      front_in.v  = req_data.brightness_pct;

      priority if (req_data.hue_degrees >= 9'd300) begin
         front_in.sector = hsv_pkg::SECTOR_MAGENTA_RED;
         base = 9'd300;
      end else if (req_data.hue_degrees >= 9'd240) begin
         front_in.sector = hsv_pkg::SECTOR_BLUE_MAGENTA;
         base = 9'd240;
      end else if (req_data.hue_degrees >= 9'd180) begin
         front_in.sector = hsv_pkg::SECTOR_CYAN_BLUE;
         base = 9'd180;
      end else if (req_data.hue_degrees >= 9'd120) begin
         front_in.sector = hsv_pkg::SECTOR_GREEN_CYAN;
         base = 9'd120;
      end else if (req_data.hue_degrees >= 9'd60) begin
         front_in.sector = hsv_pkg::SECTOR_YELLOW_GREEN;
         base = 9'd60;
      end else begin
         front_in.sector = hsv_pkg::SECTOR_RED_YELLOW;
         base = 9'd0;
      end

      // rising weight in even sectors, falling in odd ones; hue 360 gives zero
      offs = req_data.hue_degrees - base;
      if (front_in.sector[0]) begin
         front_in.k = hsv_pkg::K_W'(9'd60 - offs);
      end else begin
         front_in.k = hsv_pkg::K_W'(offs);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

/* hw/rtl/hsv_mix.sv */
`timescale 1ns / 1ps

module hsv_mix (
   input  logic                 clock,
   input  hsv_pkg::mix_en_type  en,
   input  hsv_pkg::front_type   front,
   output hsv_pkg::mix_type     mix
);

   typedef struct packed {
      logic                      in_range;
      hsv_pkg::sector_type       sector;
      logic [hsv_pkg::NUM_W-1:0] c;
      logic [hsv_pkg::NUM_W-1:0] x;
      logic [hsv_pkg::NUM_W-1:0] m;
   } mid_type;

   mid_type                   mid_ff, mid_in;
   hsv_pkg::mix_type          mix_ff, mix_in;
   logic [hsv_pkg::NUM_W-1:0] comp [3];
   logic [hsv_pkg::NUM_W-1:0] num;
   logic [hsv_pkg::NUM_W+3:0] num17;

   // chroma, secondary and offset on a common denominator of 600000
   always_comb begin
      mid_in.in_range = front.in_range;
      mid_in.sector   = front.sector;
      mid_in.c = hsv_pkg::NUM_W'(front.sv) * hsv_pkg::NUM_W'(60);
      mid_in.x = hsv_pkg::NUM_W'(front.sv) * hsv_pkg::NUM_W'(front.k);
      mid_in.m = hsv_pkg::NUM_W'(front.v) * hsv_pkg::NUM_W'(6000) -
                 hsv_pkg::NUM_W'(front.sv) * hsv_pkg::NUM_W'(60);
   end

   always_ff @(posedge clock) begin
      if (en.s2) begin
         mid_ff <= mid_in;
      end
   end

   // route components by sector, add offset, scale by 17/64 toward 255/600000 = 17/40000
   always_comb begin
      unique case (mid_ff.sector)
         hsv_pkg::SECTOR_RED_YELLOW: begin
            comp[0] = mid_ff.c; comp[1] = mid_ff.x; comp[2] = '0;
         end
         hsv_pkg::SECTOR_YELLOW_GREEN: begin
            comp[0] = mid_ff.x; comp[1] = mid_ff.c; comp[2] = '0;
         end
         hsv_pkg::SECTOR_GREEN_CYAN: begin
            comp[0] = '0; comp[1] = mid_ff.c; comp[2] = mid_ff.x;
         end
         hsv_pkg::SECTOR_CYAN_BLUE: begin
            comp[0] = '0; comp[1] = mid_ff.x; comp[2] = mid_ff.c;
         end
         hsv_pkg::SECTOR_BLUE_MAGENTA: begin
            comp[0] = mid_ff.x; comp[1] = '0; comp[2] = mid_ff.c;
         end
         default: begin
            comp[0] = mid_ff.c; comp[1] = '0; comp[2] = mid_ff.x;
         end
      endcase

      mix_in.in_range = mid_ff.in_range;
      num   = '0;
      num17 = '0;
      for (int i = 0; i < 3; i++) begin
         num   = comp[i] + mid_ff.m;
         num17 = {num, 4'b0000} + (hsv_pkg::NUM_W + 4)'(num);
         // out of range forces the channel to zero
         mix_in.y[2-i] = mid_ff.in_range ? num17[hsv_pkg::NUM_W+3:6] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en.s3) begin
         mix_ff <= mix_in;
      end
   end

   assign mix = mix_ff;

endmodule

/* hw/rtl/hsv_level.sv */
`timescale 1ns / 1ps

module hsv_level (
   input  logic                        clock,
   input  hsv_pkg::level_en_type       en,
   input  logic [hsv_pkg::Y_W-1:0]     y,
   output logic [hsv_pkg::LEVEL_W-1:0] level
);

   logic [hsv_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [hsv_pkg::LEVEL_W-1:0] level_ff, level_in;

   // divide by 625 through the reciprocal product
   assign prod_in = hsv_pkg::PROD_W'(y) * hsv_pkg::PROD_W'(hsv_pkg::RECIP);

   always_ff @(posedge clock) begin
      if (en.s4) begin
         prod_ff <= prod_in;
      end
   end

   // quotient stays below 256
   assign level_in =
      prod_ff[hsv_pkg::QUOT_SHIFT + hsv_pkg::LEVEL_W - 1 : hsv_pkg::QUOT_SHIFT];

   always_ff @(posedge clock) begin
      if (en.s5) begin
         level_ff <= level_in;
      end
   end

   assign level = level_ff;

endmodule

/* hw/rtl/hsv_to_rgb_converter_top.sv */
`timescale 1ns / 1ps
// throughput: one request per cycle; stall on rsp backs up stage by stage
// stages: sector and product, chroma terms, routing and scaling,
//   reciprocal multiply, output register
// reset clears all stage valid bits; data registers are not reset

module hsv_to_rgb_converter_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  hsv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output hsv_pkg::rsp_type rsp_data
);

   localparam int LAST = hsv_pkg::STAGES - 1;

   logic [LAST:0]         valid_ff, valid_in, advance;
   hsv_pkg::front_type    front;
   hsv_pkg::mix_type      mix;
   hsv_pkg::mix_en_type   mix_en;
   hsv_pkg::level_en_type level_en;
   logic [hsv_pkg::LEVEL_W-1:0] level [3];
   logic                  rng4_ff, rng5_ff;

   // a stage moves when it is empty or the next one moves
   always_comb begin
      advance[LAST] = !valid_ff[LAST] || !rsp_stall;
      for (int i = LAST - 1; i >= 0; i--) begin
         advance[i] = !valid_ff[i] || advance[i+1];
      end
      valid_in[0] = advance[0] ? req_valid : valid_ff[0];
      for (int i = 1; i <= LAST; i++) begin
         valid_in[i] = advance[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !advance[0];

   assign mix_en.s2   = advance[1];
   assign mix_en.s3   = advance[2];
   assign level_en.s4 = advance[3];
   assign level_en.s5 = advance[4];

   hsv_front u_front (
      .clock    (clock),
      .en       (advance[0]),
      .req_data (req_data),
      .front    (front)
   );

   hsv_mix u_mix (
      .clock (clock),
      .en    (mix_en),
      .front (front),
      .mix   (mix)
   );

   // one divider pipe per channel, red first
   for (genvar g = 0; g < 3; g++) begin : g_level
      hsv_level u_level (
         .clock (clock),
         .en    (level_en),
         .y     (mix.y[2-g]),
         .level (level[g])
      );
   end

   // range flag rides alongside the divider stages
   always_ff @(posedge clock) begin
      if (advance[3]) begin
         rng4_ff <= mix.in_range;
      end
      if (advance[4]) begin
         rng5_ff <= rng4_ff;
      end
   end

   assign rsp_valid            = valid_ff[LAST];
   assign rsp_data.red_level   = level[0];
   assign rsp_data.green_level = level[1];
   assign rsp_data.blue_level  = level[2];
   assign rsp_data.in_range    = rng5_ff;

`ifndef SYNTHESIS
   a_zero_when_out_of_range: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.in_range) |->
         (rsp_data.red_level == '0 && rsp_data.green_level == '0 &&
          rsp_data.blue_level == '0))
      else $error("out-of-range request produced a nonzero color");

   a_stall_only_when_full: assert property (
      @(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("request stalled while a pipeline stage was empty");

   a_last_stage_feeds_output: assert property (
      @(posedge clock) disable iff (reset)
      (valid_ff[LAST-1] && advance[LAST]) |=> rsp_valid)
      else $error("item in the divider stage did not reach the output");
`endif

endmodule

/* dv/hsv_to_rgb_converter_top_test.sv */
`timescale 1ns / 1ps

module hsv_to_rgb_converter_top_test;

   // scaling constants of the exact integer conversion
   localparam longint unsigned SECTOR_SPAN = 60;
   localparam longint unsigned FULL_LEVEL  = 255;
   localparam longint unsigned COMMON_DEN  = 600000;
   localparam int              NUM_RANDOM  = 463;

   typedef struct packed {
      hsv_pkg::req_type stim;
      logic             typed_in;
      hsv_pkg::rsp_type want;
   } color_row_type;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   hsv_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   hsv_pkg::rsp_type rsp_data;

   int               send_gap_pct = 0;
   int               stall_pct    = 0;
   int               fault_count  = 0;
   hsv_pkg::rsp_type pending_colors[$];

   // directed requests, fixed colors only where they are obvious
   color_row_type directed_rows [23] = '{
      '{'{9'd0,   7'd0,   7'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
      '{'{9'd0,   7'd100, 7'd100}, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b1}},
      '{'{9'd360, 7'd100, 7'd100}, 1'b1, '{8'd255, 8'd0,   8'd0,   1'b1}},
      '{'{9'd120, 7'd100, 7'd100}, 1'b1, '{8'd0,   8'd255, 8'd0,   1'b1}},
      '{'{9'd240, 7'd100, 7'd100}, 1'b1, '{8'd0,   8'd0,   8'd255, 1'b1}},
      '{'{9'd0,   7'd0,   7'd100}, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}},
      '{'{9'd180, 7'd100, 7'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
      '{'{9'd511, 7'd127, 7'd127}, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
      '{'{9'd361, 7'd50,  7'd50 }, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
      '{'{9'd180, 7'd101, 7'd50 }, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
      '{'{9'd180, 7'd50,  7'd101}, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
      '{'{9'd100, 7'd127, 7'd0  }, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
      '{'{9'd0,   7'd100, 7'd127}, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
      '{'{9'd30,  7'd100, 7'd100}, 1'b0, '0},
      '{'{9'd90,  7'd100, 7'd100}, 1'b0, '0},
      '{'{9'd150, 7'd100, 7'd100}, 1'b0, '0},
      '{'{9'd210, 7'd100, 7'd100}, 1'b0, '0},
      '{'{9'd270, 7'd100, 7'd100}, 1'b0, '0},
      '{'{9'd330, 7'd100, 7'd100}, 1'b0, '0},
      '{'{9'd60,  7'd75,  7'd80 }, 1'b0, '0},
      '{'{9'd300, 7'd33,  7'd67 }, 1'b0, '0},
      '{'{9'd359, 7'd100, 7'd50 }, 1'b0, '0},
      '{'{9'd256, 7'd1,   7'd1  }, 1'b0, '0}
   };

   hsv_to_rgb_converter_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // scaled component plus offset to an 8-bit level
   function automatic logic [hsv_pkg::LEVEL_W-1:0] scale_level(
      input longint unsigned num);
      return hsv_pkg::LEVEL_W'((num * FULL_LEVEL) / COMMON_DEN);
   endfunction

   // expected color for one request, all terms on the common denominator
   function automatic hsv_pkg::rsp_type hsv_color(input hsv_pkg::req_type item);
      longint unsigned     hue, sat, bri, chroma, second, offset, hue_mod, hue_dist;
      longint unsigned     red, green, blue;
      hsv_pkg::sector_type sector;
      hsv_pkg::rsp_type    res;
      res = '0;
      hue = item.hue_degrees;
      sat = item.saturation_pct;
      bri = item.brightness_pct;
      if (hue > hsv_pkg::HUE_MAX || sat > hsv_pkg::PCT_MAX || bri > hsv_pkg::PCT_MAX) begin
         return res;
      end
      chroma   = sat * bri * SECTOR_SPAN;
      hue_mod  = hue % (2 * SECTOR_SPAN);
      hue_dist = (hue_mod >= SECTOR_SPAN) ? hue_mod - SECTOR_SPAN
                                          : SECTOR_SPAN - hue_mod;
      second   = sat * bri * (SECTOR_SPAN - hue_dist);
      offset   = bri * (COMMON_DEN / hsv_pkg::PCT_MAX) - chroma;
      // the top of the wheel folds into the last sector
      if (hue >= 5 * SECTOR_SPAN) begin
         sector = hsv_pkg::SECTOR_MAGENTA_RED;
      end else begin
         sector = hsv_pkg::sector_type'(hue / SECTOR_SPAN);
      end
      unique case (sector)
         hsv_pkg::SECTOR_RED_YELLOW: begin
            red = chroma; green = second; blue = 0;
         end
         hsv_pkg::SECTOR_YELLOW_GREEN: begin
            red = second; green = chroma; blue = 0;
         end
         hsv_pkg::SECTOR_GREEN_CYAN: begin
            red = 0; green = chroma; blue = second;
         end
         hsv_pkg::SECTOR_CYAN_BLUE: begin
            red = 0; green = second; blue = chroma;
         end
         hsv_pkg::SECTOR_BLUE_MAGENTA: begin
            red = second; green = 0; blue = chroma;
         end
         default: begin
            red = chroma; green = 0; blue = second;
         end
      endcase
      res.red_level   = scale_level(red + offset);
      res.green_level = scale_level(green + offset);
      res.blue_level  = scale_level(blue + offset);
      res.in_range    = 1'b1;
      return res;
   endfunction

   // mostly in-range colors with edges, some raw field values
   function automatic hsv_pkg::req_type random_color();
      hsv_pkg::req_type item;
      if ($urandom_range(9) == 0) begin
         item.hue_degrees    = hsv_pkg::HUE_W'($urandom_range(511));
         item.saturation_pct = hsv_pkg::PCT_W'($urandom_range(127));
         item.brightness_pct = hsv_pkg::PCT_W'($urandom_range(127));
      end else begin
         item.hue_degrees    = hsv_pkg::HUE_W'($urandom_range(hsv_pkg::HUE_MAX));
         item.saturation_pct = hsv_pkg::PCT_W'($urandom_range(hsv_pkg::PCT_MAX));
         item.brightness_pct = hsv_pkg::PCT_W'($urandom_range(hsv_pkg::PCT_MAX));
         if ($urandom_range(7) == 0) begin
            item.saturation_pct = $urandom_range(1) ? hsv_pkg::PCT_W'(hsv_pkg::PCT_MAX) : '0;
         end
         if ($urandom_range(7) == 0) begin
            item.brightness_pct = $urandom_range(1) ? hsv_pkg::PCT_W'(hsv_pkg::PCT_MAX) : '0;
         end
      end
      return item;
   endfunction

   task automatic note_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   // send one request and queue its expected color once it is taken
   task automatic send_color(input hsv_pkg::req_type item, input logic typed_in,
                             input hsv_pkg::rsp_type want);
      logic             taken;
      hsv_pkg::rsp_type exp_color;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         if (taken) begin
            exp_color      = typed_in ? want : hsv_color(item);
            pending_colors = {pending_colors, exp_color};
         end
         @(posedge clock);
      end
   endtask

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // compare each taken color with the oldest expectation
   always @(negedge clock) begin
      hsv_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_colors.size() == 0) begin
            note_fault($sformatf("unexpected color r=%0d g=%0d b=%0d ok=%0d",
               rsp_data.red_level, rsp_data.green_level, rsp_data.blue_level,
               rsp_data.in_range));
         end else begin
            want = pending_colors.pop_front();
            if (rsp_data.red_level !== want.red_level ||
                rsp_data.green_level !== want.green_level ||
                rsp_data.blue_level !== want.blue_level ||
                rsp_data.in_range !== want.in_range) begin
               note_fault($sformatf({"color mismatch: expected r=%0d g=%0d b=%0d ok=%0d,",
                                     " got r=%0d g=%0d b=%0d ok=%0d"},
                  want.red_level, want.green_level, want.blue_level, want.in_range,
                  rsp_data.red_level, rsp_data.green_level, rsp_data.blue_level,
                  rsp_data.in_range));
            end
         end
      end
   end

   // stimulus
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed requests without idling
      foreach (directed_rows[i]) begin
         send_color(directed_rows[i].stim, directed_rows[i].typed_in, directed_rows[i].want);
      end

      // random requests in idling phases: none, sender, receiver, both
      for (int phase = 0; phase < 4; phase++) begin
         send_gap_pct = (phase == 1) ? 66 : (phase == 3) ? 11 : 0;
         stall_pct    = (phase == 2) ? 66 : (phase == 3) ? 11 : 0;
         repeat (NUM_RANDOM) send_color(random_color(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      // drain and watch for stray colors
      stall_pct = 0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (4 * hsv_pkg::STAGES) @(posedge clock);
      if (fault_count == 0) begin
         $display("PASS hsv_to_rgb_converter_top");
      end else begin
         $display("FAIL hsv_to_rgb_converter_top");
      end
      $finish;
   end

   // run limit
   initial begin
      #400000;
      $display("FAIL hsv_to_rgb_converter_top");
      $finish;
   end

endmodule
